>>> src/edg_pkg.sv
// Shared types and constants for the Elias-delta gap encoder.
package edg_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned CodeW    = 43;
  localparam int unsigned LenW     = 6;
  localparam int unsigned PhaseW   = 3;

  localparam logic [ValueW-1:0] GapMax = '1;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } edg_in_t;

  typedef struct packed {
    logic [CodeW-1:0]  code_bits;
    logic [LenW-1:0]   code_len;
    logic [PhaseW-1:0] pad_len;
    logic              end_of_list;
    logic              order_error;
  } edg_out_t;

  typedef struct packed {
    logic [CodeW-1:0] bits;
    logic [LenW-1:0]  len;
  } edg_code_t;

endpackage

>>> src/elias_delta_gap_encoder.sv
// Top level of the Elias-delta gap encoder: state, handshakes, result register.
//
// Usage:
//   in_*  : valid/ready channel, one list element per transaction (value, last).
//   out_* : valid/ready channel, exactly one result transaction per input.
//   Each value is coded as the gap from the previous element (0 at list start).
//   The result carries the code word (first bit in bit 0), its length, and on
//   the final element the zero padding needed to reach a byte boundary.
//   A value not above the previous one is flagged with order_error, gives an
//   empty code and leaves the running state untouched.
// Timing:
//   The result register loads at the accepting edge.
//   Throughput is one transaction per cycle unless stalled; the gap subtract,
//   two priority encoders and the code shifters all sit before the result register.
//   in_ready is high whenever the result register is empty or being drained,
//   so a new element is taken in the same cycle the old result leaves.
// Reset (rst_n low, synchronous): result register empties, previous value and
//   bit phase return to zero.
// Stall: while out_valid is high and out_ready low the result holds and
//   in_ready drops, so no transaction is lost.
module elias_delta_gap_encoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  edg_pkg::edg_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output edg_pkg::edg_out_t out_data
);
  import edg_pkg::*;

  logic [ValueW-1:0] prev_r, prev_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic              out_valid_r;
  edg_out_t          out_r, out_nxt;

  logic              in_accept;
  logic [ValueW-1:0] gap;
  logic [ValueW-1:0] v;
  logic              err;
  logic [PhaseW-1:0] phase_sum;
  edg_code_t         code;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign gap = in_data.value - prev_r;
  assign v   = gap + ValueW'(1);
  assign err = (in_data.value <= prev_r) || (gap == GapMax);

  edg_code u_code (
    .v    (v),
    .code (code)
  );

  always_comb begin
    phase_sum = phase_r + code.len[PhaseW-1:0];
    prev_nxt  = prev_r;
    phase_nxt = phase_r;
    out_nxt.end_of_list = in_data.last;
    out_nxt.order_error = err;
    if (err) begin
      out_nxt.code_bits = '0;
      out_nxt.code_len  = '0;
      out_nxt.pad_len   = '0;
    end else begin
      out_nxt.code_bits = code.bits;
      out_nxt.code_len  = code.len;
      if (in_data.last) begin
        // pad to byte boundary, then start a fresh list
        out_nxt.pad_len = PhaseW'(0) - phase_sum;
        prev_nxt        = '0;
        phase_nxt       = '0;
      end else begin
        out_nxt.pad_len = '0;
        prev_nxt        = in_data.value;
        phase_nxt       = phase_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      phase_r     <= '0;
    end else begin
      if (in_accept) begin
        out_valid_r <= 1'b1;
        prev_r      <= prev_nxt;
        phase_r     <= phase_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.order_error |-> out_r.code_len == '0 && out_r.pad_len == '0)
    else $error("order error result carries code bits");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.order_error |-> out_r.code_len >= 6'd3 && out_r.code_len <= 6'd43)
    else $error("code length out of range");

  a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.end_of_list |-> out_r.pad_len == '0)
    else $error("padding on non-final result");

  a_list_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last && !err |=> prev_r == '0 && phase_r == '0)
    else $error("state not cleared after final element");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && err |=> $stable(prev_r) && $stable(phase_r))
    else $error("state changed on order error");
`endif

endmodule

>>> src/edg_code.sv
// Combinational Elias-delta code word builder for one v = gap + 1.
module edg_code (
  input  logic [edg_pkg::ValueW-1:0] v,
  output edg_pkg::edg_code_t         code
);
  import edg_pkg::*;

  function automatic logic [4:0] msb32(input logic [31:0] x);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [2:0] msb6(input logic [5:0] x);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 6; i++) begin
      if (x[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  logic [4:0]       l;
  logic [5:0]       lp1;
  logic [2:0]       ll;
  logic [3:0]       sh_ones;
  logic [3:0]       sh_len;
  logic [3:0]       sh_val;
  logic [CodeW-1:0] ones;
  logic [CodeW-1:0] len_part;
  logic [CodeW-1:0] val_part;

  always_comb begin
    l       = msb32(v);
    lp1     = {1'b0, l} + 6'd1;
    ll      = msb6(lp1);
    sh_ones = {1'b0, ll} + 4'd1;
    sh_len  = {1'b0, ll} + 4'd2;
    sh_val  = {ll, 1'b0} + 4'd2;
    // unary prefix: ll+1 ones then the terminating zero
    ones     = (CodeW'(1) << sh_ones) - CodeW'(1);
    len_part = ({{(CodeW-6){1'b0}}, lp1} & ((CodeW'(1) << ll) - CodeW'(1))) << sh_len;
    val_part = ({{(CodeW-ValueW){1'b0}}, v} & ((CodeW'(1) << l) - CodeW'(1))) << sh_val;
    code.bits = ones | len_part | val_part;
    code.len  = {2'b00, ll, 1'b0} + 6'd2 + {1'b0, l};
  end

endmodule

>>> tb/sv/tb_elias_delta_gap_encoder.sv
// Self-checking testbench for the Elias-delta gap encoder with a built-in gap-code predictor.
module tb_elias_delta_gap_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import edg_pkg::*;

  // Run sizing: random list elements, tail without idling, cycle limit
  localparam int RandomItems = 1400;
  localparam int TailItems   = 150;
  localparam int CycleLimit  = 400000;
  localparam int LongHold    = 250;
  localparam int MaxPrinted  = 40;

  // A pending element plus a flag that holds it back until every result is in
  typedef struct packed {
    edg_in_t item;
    logic    drain_first;
  } pending_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  edg_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  edg_out_t out_data;

  pending_t pending_items[$];
  edg_out_t expected_codes[$];

  // Predictor state: mirrors previous element and bit phase inside the block
  logic [ValueW-1:0] model_prev  = '0;
  logic [PhaseW-1:0] model_phase = '0;

  // Generator's own view of the previous element, used to build valid lists
  logic [ValueW-1:0] gen_prev = '0;

  // Transaction counters, written only with nonblocking assignments
  int n_sent      = 0;
  int n_seen      = 0;
  int cycle_count = 0;
  logic tail_mode = 1'b0;

  int mismatch_count = 0;

  always #1 clk = ~clk;

  elias_delta_gap_encoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Work out the code word for one accepted element and advance the
  // predictor state. An out-of-order element (or a maximal gap) gives an
  // empty code, raises order_error and leaves the state alone, even on last.
  function automatic edg_out_t predict_gap_code(edg_in_t item);
    edg_out_t          res;
    logic [ValueW-1:0] gap;
    logic [ValueW-1:0] v;
    logic [5:0]        l_plus1;
    logic [PhaseW-1:0] phase_sum;
    int unsigned       l;
    int unsigned       ll;
    int unsigned       len;
    int unsigned       i;
    res = '0;
    res.end_of_list = item.last;
    gap = item.value - model_prev;
    if (item.value <= model_prev || gap == GapMax) begin
      res.order_error = 1'b1;
      return res;
    end
    v = gap + 1'b1;
    // floor(log2) by highest set bit
    l = 0;
    for (i = 0; i < ValueW; i++) begin
      if (v[i]) l = i;
    end
    l_plus1 = 6'(l + 1);
    ll = 0;
    for (i = 0; i < 6; i++) begin
      if (l_plus1[i]) ll = i;
    end
    // unary prefix of ll+1 ones, then the terminating zero
    len = 0;
    for (i = 0; i <= ll; i++) begin
      res.code_bits[len] = 1'b1;
      len++;
    end
    len++;
    // ll low bits of l+1, then l low bits of v, LSB first
    for (i = 0; i < ll; i++) begin
      res.code_bits[len] = l_plus1[i];
      len++;
    end
    for (i = 0; i < l; i++) begin
      res.code_bits[len] = v[i];
      len++;
    end
    res.code_len = LenW'(len);
    phase_sum = model_phase + PhaseW'(len);
    if (item.last) begin
      // padding up to the next byte boundary, then the list starts over
      res.pad_len = PhaseW'(0) - phase_sum;
      model_prev  = '0;
      model_phase = '0;
    end else begin
      model_prev  = item.value;
      model_phase = phase_sum;
    end
    return res;
  endfunction

  // Queue one element for the driver. The generator tracks the list state so
  // that random lists stay well formed; an element equal to the all-ones value
  // must close its list, or every later element would be out of order.
  task automatic add_item(input logic [ValueW-1:0] value, input logic last,
                          input logic drain);
    pending_t p;
    logic     bad;
    bad = (value <= gen_prev) || (value - gen_prev == GapMax);
    if (!bad && value == GapMax) last = 1'b1;
    if (!bad) gen_prev = last ? '0 : value;
    p.item.value  = value;
    p.item.last   = last;
    p.drain_first = drain;
    pending_items.insert(pending_items.size(), p);
  endtask

  task automatic report_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= MaxPrinted)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Stimulus: directed corner cases first, then random lists with noise
  initial begin
    int               n_random;
    int               list_len;
    int               j;
    logic [ValueW-1:0] value;
    longint unsigned  gap;
    longint unsigned  next;
    logic             drain;

    // directed part
    add_item(32'h0000_0000, 1'b0, 1'b0); // first element zero: out of order
    add_item(32'h0000_0001, 1'b0, 1'b0); // smallest gap
    add_item(32'h0000_0001, 1'b0, 1'b0); // repeated element
    add_item(32'h0000_0000, 1'b1, 1'b0); // smaller, flagged on last: state kept
    add_item(32'h0000_0002, 1'b0, 1'b0);
    add_item(32'h0000_0003, 1'b0, 1'b0);
    add_item(32'h0000_0006, 1'b0, 1'b0); // v = 4
    add_item(32'h0000_000D, 1'b0, 1'b0); // v = 8
    add_item(32'h0000_0100, 1'b1, 1'b0); // close list with padding
    add_item(32'hFFFF_FFFF, 1'b1, 1'b0); // all-ones gap from zero: flagged
    add_item(32'hFFFF_FFFE, 1'b0, 1'b0); // longest code word
    add_item(32'hFFFF_FFFF, 1'b1, 1'b0); // gap one up to the top value
    add_item(32'h8000_0000, 1'b0, 1'b0); // l = 31 with v just above 2^31
    add_item(32'hFFFF_FFFF, 1'b1, 1'b0); // v = 2^31 exactly
    add_item(32'h0000_0007, 1'b0, 1'b1); // v = 8, held until the pipe drains
    add_item(32'h0000_0016, 1'b0, 1'b0); // v = 16
    add_item(32'h0000_0035, 1'b0, 1'b0); // v = 32
    add_item(32'h0001_0034, 1'b0, 1'b0); // v = 2^16
    add_item(32'h0001_0034, 1'b1, 1'b0); // equal on last: flagged, no clear
    add_item(32'h5555_5555, 1'b0, 1'b0);
    add_item(32'hAAAA_AAAA, 1'b1, 1'b0);
    add_item(32'h0000_0001, 1'b1, 1'b0); // single element list
    add_item(32'h0000_00FF, 1'b1, 1'b0);

    // random lists: mostly well formed, some out-of-order noise
    n_random = 0;
    while (n_random < RandomItems) begin
      list_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (j = 0; j < list_len && n_random < RandomItems; j++) begin
        drain = (n_random % 350 == 0);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0:       value = (gen_prev == 0) ? '0 : $urandom_range(0, gen_prev);
            1:       value = (gen_prev == 0) ? GapMax : gen_prev;
            default: value = $urandom;
          endcase
          add_item(value, 1'($urandom_range(0, 1)), drain);
        end else begin
          // wide spread of gap sizes: shift a random word down by 0..31
          gap  = 64'd1 + 64'($urandom >> $urandom_range(0, 31));
          next = 64'(gen_prev) + gap;
          value = (next > 64'hFFFF_FFFF) ? GapMax : next[ValueW-1:0];
          add_item(value, j == list_len - 1, drain);
        end
        n_random++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all stimulus to go out and every result to come back
    while (pending_items.size() != 0 || in_valid || n_sent != n_seen) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_codes.size() != 0) begin
      mismatch_count += expected_codes.size();
      $display("%0t: %0d expected results never arrived", $time, expected_codes.size());
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Driver: predicts on each accepted transaction, then loads the next
  // element when the channel is free. Random idle bursts are inserted only
  // between transactions, so valid never drops while an element is offered.
  always @(posedge clk) begin
    static int idle_left = 0;
    static int idle_pct  = 20;
    logic      accepted;
    pending_t  p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        expected_codes.insert(expected_codes.size(), predict_gap_code(in_data));
        n_sent <= n_sent + 1;
      end
      tail_mode <= (pending_items.size() < TailItems);
      if (!in_valid || in_ready) begin
        if (idle_left == 0 && pending_items.size() >= TailItems &&
            $urandom_range(0, 99) < idle_pct)
          idle_left = $urandom_range(1, 18);
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_items[0].drain_first &&
                     n_sent + int'(accepted) != n_seen) begin
          // hold this element back until every result has been checked
          in_valid <= 1'b0;
        end else begin
          p = pending_items.pop_front();
          in_data  <= p.item;
          in_valid <= 1'b1;
          // change the idle density now and then, zero included
          if (pending_items.size() % 100 == 0) begin
            case ($urandom_range(0, 2))
              0:       idle_pct = 0;
              1:       idle_pct = 15;
              default: idle_pct = 50;
            endcase
          end
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // drives out_ready with random stall bursts plus one long hold-off that
  // backs the block up while the driver keeps offering elements.
  always @(posedge clk) begin
    static int   hold_left      = 0;
    static int   stall_pct      = 20;
    static logic long_hold_done = 1'b0;
    edg_out_t    exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_seen <= n_seen + 1;
        if (expected_codes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxPrinted)
            $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
        end else begin
          exp_res = expected_codes.pop_front();
          report_field("code_bits",   64'(exp_res.code_bits),   64'(out_data.code_bits));
          report_field("code_len",    64'(exp_res.code_len),    64'(out_data.code_len));
          report_field("pad_len",     64'(exp_res.pad_len),     64'(out_data.pad_len));
          report_field("end_of_list", 64'(exp_res.end_of_list), 64'(out_data.end_of_list));
          report_field("order_error", 64'(exp_res.order_error), 64'(out_data.order_error));
        end
      end
      if (cycle_count % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      if (hold_left == 0 && !tail_mode && $urandom_range(0, 99) < stall_pct)
        hold_left = $urandom_range(1, 18);
      if (!long_hold_done && n_seen >= 400) begin
        hold_left      = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

>>> files.f
src/edg_pkg.sv
src/edg_code.sv
src/elias_delta_gap_encoder.sv
tb/sv/tb_elias_delta_gap_encoder.sv
